// ===== rtl/qrp_pkg.sv =====
// Shared constants, types and functions for the relative attitude pipeline.
package qrp_pkg;

  localparam int ANGLE_BITS_DEF    = 16;
  localparam int QUAT_BITS_DEF     = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  // Internal fixed point: Q.24 values held in a wide signed word
  localparam int IFRAC = 24;
  localparam int VW    = 40;
  localparam int PW    = 2 * VW;

  localparam logic signed [VW-1:0] ONE_Q  = VW'(64'sd1 << IFRAC);
  localparam logic signed [VW-1:0] KINV_Q = VW'(64'sd10188012);
  localparam logic [31:0] HALF_TURN       = 32'h8000_0000;

  typedef logic signed [VW-1:0] val_t;
  typedef logic signed [PW-1:0] prod_t;

  // Arctangent table, one entry per rotation
  function automatic logic [31:0] atan_entry(input int i);
    logic [31:0] t [32];
    t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
          32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
          32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
          32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
          32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
          32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
          32'h00000001, 32'h00000000};
    return t[i[4:0]];
  endfunction

  // Vectoring data handed between cells
  typedef struct packed {
    val_t        x;
    val_t        y;
    logic [31:0] ang;
  } vec_t;

  // Rotation data handed between cells
  typedef struct packed {
    val_t              x;
    val_t              y;
    logic signed [32:0] z;
  } rot_t;

  // Rounded output of a 32-bit binary angle
  function automatic logic [31:0] angle_round(input logic signed [32:0] a, input int ab);
    logic signed [33:0] s;
    s = 34'(a) + ((ab < 32) ? (34'sd1 <<< (31 - ab)) : 34'sd0);
    return 32'(s >>> (32 - ab));
  endfunction

endpackage

// ===== rtl/qrp_vec_cell.sv =====
// One vectoring CORDIC cell: a single micro-rotation toward the x axis.
module qrp_vec_cell #(
  parameter int SHIFT = 0
) (
  input  logic          clk,
  input  qrp_pkg::vec_t vin,
  output qrp_pkg::vec_t vout
);

  qrp_pkg::vec_t vout_nxt;

  // Rotate by the table angle toward y = 0
  always_comb begin
    vout_nxt = vin;
    if (SHIFT < 32) begin
      if (!vin.y[qrp_pkg::VW-1]) begin
        vout_nxt.x   = vin.x + (vin.y >>> SHIFT);
        vout_nxt.y   = vin.y - (vin.x >>> SHIFT);
        vout_nxt.ang = vin.ang + qrp_pkg::atan_entry(SHIFT);
      end else begin
        vout_nxt.x   = vin.x - (vin.y >>> SHIFT);
        vout_nxt.y   = vin.y + (vin.x >>> SHIFT);
        vout_nxt.ang = vin.ang - qrp_pkg::atan_entry(SHIFT);
      end
    end
  end

  always_ff @(posedge clk) begin
    vout <= vout_nxt;
  end

endmodule

// ===== rtl/qrp_rot_cell.sv =====
// One rotation CORDIC cell: a single micro-rotation driven by the residual angle.
module qrp_rot_cell #(
  parameter int SHIFT = 0
) (
  input  logic          clk,
  input  qrp_pkg::rot_t rin,
  output qrp_pkg::rot_t rout
);

  qrp_pkg::rot_t rout_nxt;

  // Rotate toward a zero residual angle
  always_comb begin
    rout_nxt = rin;
    if (SHIFT < 32) begin
      if (!rin.z[32]) begin
        rout_nxt.x = rin.x - (rin.y >>> SHIFT);
        rout_nxt.y = rin.y + (rin.x >>> SHIFT);
        rout_nxt.z = rin.z - $signed({1'b0, qrp_pkg::atan_entry(SHIFT)});
      end else begin
        rout_nxt.x = rin.x + (rin.y >>> SHIFT);
        rout_nxt.y = rin.y - (rin.x >>> SHIFT);
        rout_nxt.z = rin.z + $signed({1'b0, qrp_pkg::atan_entry(SHIFT)});
      end
    end
  end

  always_ff @(posedge clk) begin
    rout <= rout_nxt;
  end

endmodule

// ===== rtl/qrp_atan2.sv =====
// Pipelined atan2 built from a chain of vectoring cells.
module qrp_atan2 #(
  parameter int STAGES = qrp_pkg::CORDIC_STAGES_DEF
) (
  input  logic         clk,
  input  qrp_pkg::val_t y,
  input  qrp_pkg::val_t x,
  output logic [31:0]  ang
);

  qrp_pkg::vec_t chain [STAGES+1];
  logic          zero_r [STAGES+1];

  // Fold the left half plane into the right one
  always_ff @(posedge clk) begin
    zero_r[0] <= (x == '0) && (y == '0);
    if (x[qrp_pkg::VW-1]) begin
      chain[0].x   <= -x;
      chain[0].y   <= -y;
      chain[0].ang <= qrp_pkg::HALF_TURN;
    end else begin
      chain[0].x   <= x;
      chain[0].y   <= y;
      chain[0].ang <= '0;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    qrp_vec_cell #(.SHIFT(i)) u_cell (.clk(clk), .vin(chain[i]), .vout(chain[i+1]));
    always_ff @(posedge clk) begin
      zero_r[i+1] <= zero_r[i];
    end
  end

  assign ang = zero_r[STAGES] ? '0 : chain[STAGES].ang;

endmodule

// ===== rtl/qrp_sincos.sv =====
// Pipelined sine and cosine built from a chain of rotation cells.
module qrp_sincos #(
  parameter int STAGES = qrp_pkg::CORDIC_STAGES_DEF
) (
  input  logic                clk,
  input  logic signed [32:0]  z,
  output qrp_pkg::val_t       c,
  output qrp_pkg::val_t       s
);

  qrp_pkg::rot_t chain [STAGES+1];

  // Load the gain-compensated unit vector
  always_ff @(posedge clk) begin
    chain[0].x <= qrp_pkg::KINV_Q;
    chain[0].y <= '0;
    chain[0].z <= z;
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    qrp_rot_cell #(.SHIFT(i)) u_cell (.clk(clk), .rin(chain[i]), .rout(chain[i+1]));
  end

  assign c = chain[STAGES].x;
  assign s = chain[STAGES].y;

endmodule

// ===== rtl/qrp_isqrt.sv =====
// Pipelined integer square root, one result bit per cell.
module qrp_isqrt (
  input  logic        clk,
  input  logic [49:0] n,
  output logic [24:0] root
);

  localparam int STEPS = 25;

  logic [49:0] rem_r [STEPS+1];
  logic [49:0] res_r [STEPS+1];

  always_ff @(posedge clk) begin
    rem_r[0] <= n;
    res_r[0] <= '0;
  end

  // Decide one root bit per stage, highest first
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic [49:0] BIT = 50'd1 << (2 * (STEPS - 1 - i));
    always_ff @(posedge clk) begin
      if (rem_r[i] >= res_r[i] + BIT) begin
        rem_r[i+1] <= rem_r[i] - (res_r[i] + BIT);
        res_r[i+1] <= (res_r[i] >> 1) + BIT;
      end else begin
        rem_r[i+1] <= rem_r[i];
        res_r[i+1] <= res_r[i] >> 1;
      end
    end
  end

  assign root = res_r[STEPS][24:0];

endmodule

// ===== rtl/quaternion_relative_pitch.sv =====
// Top level: chassis yaw, chassis pitch and relative gimbal pitch from two quaternions.
//
// Usage: raise start with a request on the in_ ports; a request is taken at every
// clock edge where start is high (busy is always low, so one request per cycle).
// Results appear on the out_ ports for one cycle, marked by out_valid. From 10
// CORDIC stages up the relative pitch path is the longer one; below 10 stages the
// pitch path is the longer one. Throughput is one request per cycle: each CORDIC
// and square root cell is a pipeline stage.
// The relative pitch path is the chain: yaw atan2, then the half-error sin/cos,
// then the quaternion product and rotation matrix, then the relative pitch atan2.
// Reset (rst_n low, synchronous) clears the valid pipeline; data in flight is
// dropped. The receiver cannot stall: every result is shown exactly once.
module quaternion_relative_pitch #(
  parameter int ANGLE_BITS    = qrp_pkg::ANGLE_BITS_DEF,
  parameter int QUAT_BITS     = qrp_pkg::QUAT_BITS_DEF,
  parameter int CORDIC_STAGES = qrp_pkg::CORDIC_STAGES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [QUAT_BITS-1:0]  in_chassis_w,
  input  logic signed [QUAT_BITS-1:0]  in_chassis_x,
  input  logic signed [QUAT_BITS-1:0]  in_chassis_y,
  input  logic signed [QUAT_BITS-1:0]  in_chassis_z,
  input  logic signed [QUAT_BITS-1:0]  in_gimbal_w,
  input  logic signed [QUAT_BITS-1:0]  in_gimbal_x,
  input  logic signed [QUAT_BITS-1:0]  in_gimbal_y,
  input  logic signed [QUAT_BITS-1:0]  in_gimbal_z,
  input  logic signed [ANGLE_BITS-1:0] in_yaw_joint_angle,
  output logic                         out_valid,
  output logic signed [ANGLE_BITS-1:0] out_chassis_yaw,
  output logic signed [ANGLE_BITS-1:0] out_chassis_pitch,
  output logic signed [ANGLE_BITS-1:0] out_relative_pitch
);

  localparam int VW  = qrp_pkg::VW;
  localparam int CS  = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;
  localparam int LA  = CS + 1;    // atan2 latency
  localparam int LSC = CS + 1;    // sin/cos latency
  localparam int LSQ = 26;        // square root latency
  // stage plan: 0 input reg, 1 products, 2 sums -> yaw atan2 (LA)
  localparam int T_YAW  = 3 + LA;          // yaw angles ready
  localparam int T_ERR  = T_YAW + 1;       // half error registered
  localparam int T_SC   = T_ERR + LSC;     // sin/cos ready
  localparam int T_A    = T_SC + 2;        // rotated chassis quaternion
  localparam int T_C    = T_A + 2;         // c row ready
  localparam int T_R    = T_C + 2;         // r31/r33 ready
  localparam int PD_LAT  = LSQ + LA;       // pitch path from stage 3
  localparam int L_REL   = T_R + LA + 1;   // relative pitch path
  localparam int L_PIT   = 4 + PD_LAT + 2; // chassis pitch path
  localparam int LATENCY = (L_REL > L_PIT) ? L_REL : L_PIT;
  localparam int XR      = LATENCY - L_REL;

  typedef logic signed [VW-1:0] val_t;
  typedef logic signed [2*VW-1:0] prod_t;

  assign busy = 1'b0;

  // Bring a quaternion field to Q.24
  function automatic val_t qin(input logic signed [QUAT_BITS-1:0] v);
    logic signed [63:0] w;
    w = 64'(v);
    if (QUAT_BITS - 1 <= qrp_pkg::IFRAC) return VW'(w <<< (qrp_pkg::IFRAC - QUAT_BITS + 1));
    return VW'(w >>> (QUAT_BITS - 1 - qrp_pkg::IFRAC));
  endfunction

  // Every operand stays well inside 32 signed bits, so multiply at that width
  function automatic prod_t mul(input val_t a, input val_t b);
    logic signed [31:0] an, bn;
    logic signed [63:0] p;
    an = a[31:0];
    bn = b[31:0];
    p = an * bn;
    return prod_t'(p);
  endfunction

  // Valid pipeline
  logic [LATENCY-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else        vld_r <= {vld_r[LATENCY-2:0], start};
  end
  assign out_valid = vld_r[LATENCY-1];

  // Stage 0: register inputs
  val_t cw0_r, cx0_r, cy0_r, cz0_r, gw0_r, gx0_r, gy0_r, gz0_r;
  logic [31:0] joint0_r;
  always_ff @(posedge clk) begin
    cw0_r <= qin(in_chassis_w); cx0_r <= qin(in_chassis_x);
    cy0_r <= qin(in_chassis_y); cz0_r <= qin(in_chassis_z);
    gw0_r <= qin(in_gimbal_w);  gx0_r <= qin(in_gimbal_x);
    gy0_r <= qin(in_gimbal_y);  gz0_r <= qin(in_gimbal_z);
    joint0_r <= 32'(in_yaw_joint_angle) << (32 - ANGLE_BITS);
  end

  // Stage 1: yaw and pitch products
  prod_t cwz_r, cxy_r, cyy_r, czz_r, gwz_r, gxy_r, gyy_r, gzz_r, cwy_r, cxz_r;
  always_ff @(posedge clk) begin
    cwz_r <= mul(cw0_r, cz0_r); cxy_r <= mul(cx0_r, cy0_r);
    cyy_r <= mul(cy0_r, cy0_r); czz_r <= mul(cz0_r, cz0_r);
    gwz_r <= mul(gw0_r, gz0_r); gxy_r <= mul(gx0_r, gy0_r);
    gyy_r <= mul(gy0_r, gy0_r); gzz_r <= mul(gz0_r, gz0_r);
    cwy_r <= mul(cw0_r, cy0_r); cxz_r <= mul(cx0_r, cz0_r);
  end

  // Stage 2: sums for the two yaw angles and the pitch sine
  val_t cnum_r, cden_r, gnum_r, gden_r, sp_r;
  prod_t sp_w;
  always_comb begin
    sp_w = (cwy_r - cxz_r) >>> (qrp_pkg::IFRAC - 1);
  end
  always_ff @(posedge clk) begin
    cnum_r <= VW'((cwz_r + cxy_r) >>> (qrp_pkg::IFRAC - 1));
    cden_r <= qrp_pkg::ONE_Q - VW'((cyy_r + czz_r) >>> (qrp_pkg::IFRAC - 1));
    gnum_r <= VW'((gwz_r + gxy_r) >>> (qrp_pkg::IFRAC - 1));
    gden_r <= qrp_pkg::ONE_Q - VW'((gyy_r + gzz_r) >>> (qrp_pkg::IFRAC - 1));
    if (sp_w > prod_t'(qrp_pkg::ONE_Q))       sp_r <= qrp_pkg::ONE_Q;
    else if (sp_w < -prod_t'(qrp_pkg::ONE_Q)) sp_r <= -qrp_pkg::ONE_Q;
    else                                      sp_r <= VW'(sp_w);
  end

  // Yaw angles
  logic [31:0] cyaw, gyaw;
  qrp_atan2 #(.STAGES(CS)) u_cyaw (.clk(clk), .y(cnum_r), .x(cden_r), .ang(cyaw));
  qrp_atan2 #(.STAGES(CS)) u_gyaw (.clk(clk), .y(gnum_r), .x(gden_r), .ang(gyaw));

  // Pitch: square of the cosine then root, then atan2
  logic [49:0] cp2_r;
  val_t        sp3_r;
  logic [24:0] cp_root;
  always_ff @(posedge clk) begin
    cp2_r <= 50'((64'sd1 << 48) - mul(sp_r, sp_r));
    sp3_r <= sp_r;
  end
  val_t sp_d [LSQ];
  always_ff @(posedge clk) begin
    sp_d[0] <= sp3_r;
    for (int i = 1; i < LSQ; i++) sp_d[i] <= sp_d[i-1];
  end
  qrp_isqrt u_sqrt (.clk(clk), .n(cp2_r), .root(cp_root));
  logic [31:0] pang;
  qrp_atan2 #(.STAGES(CS)) u_pitch (.clk(clk), .y(sp_d[LSQ-1]), .x(VW'({1'b0, cp_root})),
                                     .ang(pang));

  // Delay lines: quaternions and joint to the yaw-ready stage
  localparam int DQ = T_YAW;
  val_t q_d [DQ][8];
  logic [31:0] j_d [DQ];
  always_ff @(posedge clk) begin
    q_d[0][0] <= cw0_r; q_d[0][1] <= cx0_r; q_d[0][2] <= cy0_r; q_d[0][3] <= cz0_r;
    q_d[0][4] <= gw0_r; q_d[0][5] <= gx0_r; q_d[0][6] <= gy0_r; q_d[0][7] <= gz0_r;
    j_d[0] <= joint0_r;
    for (int i = 1; i < DQ; i++) begin
      q_d[i] <= q_d[i-1];
      j_d[i] <= j_d[i-1];
    end
  end

  // Half yaw error
  logic [31:0] err;
  logic signed [32:0] herr_r;
  assign err = gyaw - cyaw - j_d[DQ-2];
  always_ff @(posedge clk) begin
    herr_r <= 33'($signed(err) >>> 1);
  end

  val_t hc, hs;
  qrp_sincos #(.STAGES(CS)) u_sc (.clk(clk), .z(herr_r), .c(hc), .s(hs));

  // Quaternions onward to the sin/cos output and beyond
  localparam int DQ2 = T_C - T_YAW + 1;
  val_t q2_d [DQ2][8];
  always_ff @(posedge clk) begin
    q2_d[0] <= q_d[DQ-2];
    for (int i = 1; i < DQ2; i++) q2_d[i] <= q2_d[i-1];
  end
  // chassis parts alongside the sin/cos output
  localparam int IA = T_SC - T_YAW - 1;
  val_t cw_a, cx_a, cy_a, cz_a;
  assign cw_a = q2_d[IA][0]; assign cx_a = q2_d[IA][1];
  assign cy_a = q2_d[IA][2]; assign cz_a = q2_d[IA][3];

  // Rotate chassis quaternion about z
  prod_t p0_r, p1_r, p2_r, p3_r, p4_r, p5_r, p6_r, p7_r;
  always_ff @(posedge clk) begin
    p0_r <= mul(hc, cw_a); p1_r <= mul(hs, cz_a);
    p2_r <= mul(hc, cx_a); p3_r <= mul(hs, cy_a);
    p4_r <= mul(hc, cy_a); p5_r <= mul(hs, cx_a);
    p6_r <= mul(hc, cz_a); p7_r <= mul(hs, cw_a);
  end
  val_t aw_r, ax_r, ay_r, az_r;
  always_ff @(posedge clk) begin
    aw_r <= VW'((p0_r - p1_r) >>> qrp_pkg::IFRAC);
    ax_r <= VW'((p2_r - p3_r) >>> qrp_pkg::IFRAC);
    ay_r <= VW'((p4_r + p5_r) >>> qrp_pkg::IFRAC);
    az_r <= VW'((p6_r + p7_r) >>> qrp_pkg::IFRAC);
  end

  // Chassis matrix column and gimbal rows
  prod_t k0_r, k1_r, k2_r, k3_r, k4_r, k5_r;
  prod_t h0_r, h1_r, h2_r, h3_r, h4_r, h5_r, h6_r, h7_r, h8_r;
  localparam int IG = T_A - T_YAW - 1;
  val_t gw_a, gx_a, gy_a, gz_a;
  assign gw_a = q2_d[IG][4]; assign gx_a = q2_d[IG][5];
  assign gy_a = q2_d[IG][6]; assign gz_a = q2_d[IG][7];
  always_ff @(posedge clk) begin
    k0_r <= mul(ax_r, az_r); k1_r <= mul(aw_r, ay_r);
    k2_r <= mul(ay_r, az_r); k3_r <= mul(aw_r, ax_r);
    k4_r <= mul(ax_r, ax_r); k5_r <= mul(ay_r, ay_r);
    h0_r <= mul(gy_a, gy_a); h1_r <= mul(gz_a, gz_a);
    h2_r <= mul(gx_a, gy_a); h3_r <= mul(gw_a, gz_a);
    h4_r <= mul(gx_a, gz_a); h5_r <= mul(gw_a, gy_a);
    h6_r <= mul(gy_a, gz_a); h7_r <= mul(gw_a, gx_a);
    h8_r <= mul(gx_a, gx_a);
  end
  val_t c0_r, c1_r, c2_r, g00_r, g01_r, g02_r, g20_r, g21_r, g22_r;
  always_ff @(posedge clk) begin
    c0_r  <= VW'((k0_r + k1_r) >>> (qrp_pkg::IFRAC - 1));
    c1_r  <= VW'((k2_r - k3_r) >>> (qrp_pkg::IFRAC - 1));
    c2_r  <= qrp_pkg::ONE_Q - VW'((k4_r + k5_r) >>> (qrp_pkg::IFRAC - 1));
    g00_r <= qrp_pkg::ONE_Q - VW'((h0_r + h1_r) >>> (qrp_pkg::IFRAC - 1));
    g01_r <= VW'((h2_r + h3_r) >>> (qrp_pkg::IFRAC - 1));
    g02_r <= VW'((h4_r - h5_r) >>> (qrp_pkg::IFRAC - 1));
    g20_r <= VW'((h4_r + h5_r) >>> (qrp_pkg::IFRAC - 1));
    g21_r <= VW'((h6_r - h7_r) >>> (qrp_pkg::IFRAC - 1));
    g22_r <= qrp_pkg::ONE_Q - VW'((h8_r + h0_r) >>> (qrp_pkg::IFRAC - 1));
  end

  // Relative rotation terms
  prod_t m0_r, m1_r, m2_r, m3_r, m4_r, m5_r;
  always_ff @(posedge clk) begin
    m0_r <= mul(c0_r, g00_r); m1_r <= mul(c1_r, g01_r); m2_r <= mul(c2_r, g02_r);
    m3_r <= mul(c0_r, g20_r); m4_r <= mul(c1_r, g21_r); m5_r <= mul(c2_r, g22_r);
  end
  val_t nr31_r, r33_r;
  always_ff @(posedge clk) begin
    nr31_r <= -VW'((m0_r + m1_r + m2_r) >>> qrp_pkg::IFRAC);
    r33_r  <= VW'((m3_r + m4_r + m5_r) >>> qrp_pkg::IFRAC);
  end

  logic [31:0] rang;
  qrp_atan2 #(.STAGES(CS)) u_rel (.clk(clk), .y(nr31_r), .x(r33_r), .ang(rang));

  // Hold the relative pitch back when the chassis pitch path is the longer one
  logic [31:0] rang_al;
  if (XR > 0) begin : g_rel_dly
    logic [31:0] rd_r [XR];
    always_ff @(posedge clk) begin
      rd_r[0] <= rang;
      for (int i = 1; i < XR; i++) rd_r[i] <= rd_r[i-1];
    end
    assign rang_al = rd_r[XR-1];
  end else begin : g_rel_dir
    assign rang_al = rang;
  end

  // Align chassis yaw and pitch with the relative pitch
  localparam int DY = LATENCY - 1 - T_YAW;
  localparam int DP = LATENCY - 1 - (4 + PD_LAT);
  logic [31:0] yaw_d [DY];
  logic [31:0] pit_d [DP];
  logic signed [32:0] pit_s;
  always_comb begin
    pit_s = 33'($signed(pang));
    if (pit_s > 33'sd1073741824)       pit_s = 33'sd1073741824;
    else if (pit_s < -33'sd1073741824) pit_s = -33'sd1073741824;
  end
  always_ff @(posedge clk) begin
    yaw_d[0] <= cyaw;
    pit_d[0] <= 32'(pit_s);
    for (int i = 1; i < DY; i++) yaw_d[i] <= yaw_d[i-1];
    for (int i = 1; i < DP; i++) pit_d[i] <= pit_d[i-1];
  end

  // Round to output width
  logic [31:0] oy_r, op_r, orl_r;
  logic signed [32:0] pit_w;
  always_comb begin
    pit_w = (pit_d[DP-1] == 32'h4000_0000) ? 33'sd1073741824 : 33'($signed(pit_d[DP-1]));
  end
  always_ff @(posedge clk) begin
    oy_r  <= qrp_pkg::angle_round(33'($signed(yaw_d[DY-1])), ANGLE_BITS);
    op_r  <= qrp_pkg::angle_round(pit_w, ANGLE_BITS);
    orl_r <= qrp_pkg::angle_round(33'($signed(rang_al)), ANGLE_BITS);
  end
  assign out_chassis_yaw    = ANGLE_BITS'(oy_r);
  assign out_chassis_pitch  = ANGLE_BITS'(op_r);
  assign out_relative_pitch = ANGLE_BITS'(orl_r);

`ifndef NO_ASSERTIONS
  // A request's strobe is not lost between the last two registers of the valid pipeline
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[LATENCY-2] |=> out_valid) else $error("result strobe lost");
  // The block never refuses a request
  a_never_busy: assert property (@(posedge clk) !busy) else $error("busy raised");
  // Chassis pitch stays within a quarter turn
  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_chassis_pitch <= (1 <<< (ANGLE_BITS - 2)) &&
                   out_chassis_pitch >= -(1 <<< (ANGLE_BITS - 2))))
    else $error("pitch out of range");
`endif

endmodule

// ===== dv/quaternion_relative_pitch_tb.sv =====
// Self-checking testbench for the relative attitude pipeline.
module quaternion_relative_pitch_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QB = qrp_pkg::QUAT_BITS_DEF;
  localparam int AB = qrp_pkg::ANGLE_BITS_DEF;
  localparam int N_RANDOM = 480;
  localparam int TAIL_ITEMS = 100;
  localparam int DRAIN_CYCLES = 2 * qrp_pkg::CORDIC_STAGES_DEF + 40;
  localparam int STALL_LIMIT = 4000;

  typedef struct {
    logic signed [QB-1:0] cw, cx, cy, cz, gw, gx, gy, gz;
    logic signed [AB-1:0] joint;
  } attitude_req_t;

  typedef struct {
    logic signed [AB-1:0] yaw, pitch, rel_pitch;
  } angles_t;

  // Scoreboard: computes the expected angles and checks the results in order
  class angle_scoreboard;
    angles_t pending_angles[$];
    int n_checked;
    int n_errors;

    static function longint to_q24(logic signed [QB-1:0] raw);
      longint v;
      v = raw;
      return v <<< (24 - (QB - 1));
    endfunction

    static function logic [31:0] atan_step(int i);
      return qrp_pkg::atan_entry(i);
    endfunction

    static function logic [31:0] vector_angle(longint y, longint x);
      logic [31:0] ang;
      longint dx, dy;
      ang = 32'h0;
      if (x == 0 && y == 0) return 32'h0;
      if (x < 0) begin
        x = -x;
        y = -y;
        ang = qrp_pkg::HALF_TURN;
      end
      for (int i = 0; i < qrp_pkg::CORDIC_STAGES_DEF; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx; y -= dy; ang += atan_step(i);
        end else begin
          x -= dx; y += dy; ang -= atan_step(i);
        end
      end
      return ang;
    endfunction

    static function void rotate_unit(longint z, output longint c, output longint s);
      longint x, y, dx, dy, t;
      x = 10188012;
      y = 0;
      for (int i = 0; i < qrp_pkg::CORDIC_STAGES_DEF; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        t = {32'h0, atan_step(i)};
        if (z >= 0) begin
          x -= dx; y += dy; z -= t;
        end else begin
          x += dx; y -= dy; z += t;
        end
      end
      c = x;
      s = y;
    endfunction

    static function longint int_sqrt(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return longint'(res);
    endfunction

    static function longint to_signed(logic [31:0] a);
      return longint'(int'(a));
    endfunction

    static function logic signed [AB-1:0] round_out(longint a);
      longint h;
      h = (64'sd1 << (32 - AB)) >>> 1;
      return AB'((a + h) >>> (32 - AB));
    endfunction

    static function logic [31:0] heading(longint w, longint x, longint y, longint z);
      return vector_angle((w * z + x * y) >>> 23, (64'sd1 << 24) - ((y * y + z * z) >>> 23));
    endfunction

    static function angles_t predict_angles(attitude_req_t r);
      angles_t a;
      longint one, cw, cx, cy, cz, gw, gx, gy, gz, sp, cp, pitch, yaw_half, hc, hs;
      longint aw, ax, ay, az, c0, c1, c2, g00, g01, g02, g20, g21, g22, r31, r33;
      logic [31:0] cyaw, gyaw, joint, err;
      one = 64'sd1 << 24;
      cw = to_q24(r.cw); cx = to_q24(r.cx); cy = to_q24(r.cy); cz = to_q24(r.cz);
      gw = to_q24(r.gw); gx = to_q24(r.gx); gy = to_q24(r.gy); gz = to_q24(r.gz);
      joint = {r.joint, {(32 - AB){1'b0}}};
      cyaw = heading(cw, cx, cy, cz);
      gyaw = heading(gw, gx, gy, gz);
      // chassis pitch via atan2(s, sqrt(1 - s^2)), term held to +-1
      sp = (cw * cy - cx * cz) >>> 23;
      if (sp > one) sp = one;
      if (sp < -one) sp = -one;
      cp = int_sqrt(longint'(one * one - sp * sp));
      pitch = to_signed(vector_angle(sp, cp));
      if (pitch > (64'sd1 << 30)) pitch = 64'sd1 << 30;
      if (pitch < -(64'sd1 << 30)) pitch = -(64'sd1 << 30);
      // yaw mismatch wraps naturally, then halve it
      err = gyaw - cyaw - joint;
      yaw_half = to_signed(err) >>> 1;
      rotate_unit(yaw_half, hc, hs);
      aw = (hc * cw - hs * cz) >>> 24;
      ax = (hc * cx - hs * cy) >>> 24;
      ay = (hc * cy + hs * cx) >>> 24;
      az = (hc * cz + hs * cw) >>> 24;
      c0 = (ax * az + aw * ay) >>> 23;
      c1 = (ay * az - aw * ax) >>> 23;
      c2 = one - ((ax * ax + ay * ay) >>> 23);
      g00 = one - ((gy * gy + gz * gz) >>> 23);
      g01 = (gx * gy + gw * gz) >>> 23;
      g02 = (gx * gz - gw * gy) >>> 23;
      g20 = (gx * gz + gw * gy) >>> 23;
      g21 = (gy * gz - gw * gx) >>> 23;
      g22 = one - ((gx * gx + gy * gy) >>> 23);
      r31 = (c0 * g00 + c1 * g01 + c2 * g02) >>> 24;
      r33 = (c0 * g20 + c1 * g21 + c2 * g22) >>> 24;
      a.yaw = round_out(to_signed(cyaw));
      a.pitch = round_out(pitch);
      a.rel_pitch = round_out(to_signed(vector_angle(-r31, r33)));
      return a;
    endfunction

    function void note_request(attitude_req_t r);
      pending_angles.push_back(predict_angles(r));
    endfunction

    function void check_result(angles_t got);
      angles_t exp_a;
      if (pending_angles.size() == 0) begin
        $display("%0t: result with nothing expected: yaw %0d pitch %0d rel %0d",
                 $realtime, got.yaw, got.pitch, got.rel_pitch);
        n_errors++;
        return;
      end
      exp_a = pending_angles.pop_front();
      n_checked++;
      if (got.yaw !== exp_a.yaw) begin
        $display("%0t: chassis_yaw expected %0d actual %0d", $realtime, exp_a.yaw, got.yaw);
        n_errors++;
      end
      if (got.pitch !== exp_a.pitch) begin
        $display("%0t: chassis_pitch expected %0d actual %0d",
                 $realtime, exp_a.pitch, got.pitch);
        n_errors++;
      end
      if (got.rel_pitch !== exp_a.rel_pitch) begin
        $display("%0t: relative_pitch expected %0d actual %0d",
                 $realtime, exp_a.rel_pitch, got.rel_pitch);
        n_errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [QB-1:0] cw = '0, cx = '0, cy = '0, cz = '0;
  logic signed [QB-1:0] gw = '0, gx = '0, gy = '0, gz = '0;
  logic signed [AB-1:0] joint = '0;
  logic out_valid;
  logic signed [AB-1:0] out_yaw, out_pitch, out_rel;

  angle_scoreboard sb = new();
  int stall_cycles = 0;
  int n_sent = 0;

  quaternion_relative_pitch u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_chassis_w(cw), .in_chassis_x(cx), .in_chassis_y(cy), .in_chassis_z(cz),
    .in_gimbal_w(gw), .in_gimbal_x(gx), .in_gimbal_y(gy), .in_gimbal_z(gz),
    .in_yaw_joint_angle(joint), .out_valid(out_valid),
    .out_chassis_yaw(out_yaw), .out_chassis_pitch(out_pitch),
    .out_relative_pitch(out_rel)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Note accepted requests, check results, count idle cycles
  always @(posedge clk) begin
    attitude_req_t r;
    angles_t got;
    if (rst_n) begin
      if (start && !busy) begin
        r = '{cw, cx, cy, cz, gw, gx, gy, gz, joint};
        sb.note_request(r);
      end
      if (out_valid) begin
        got = '{out_yaw, out_pitch, out_rel};
        sb.check_result(got);
      end
      stall_cycles = ((start && !busy) || out_valid) ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: watchdog expired", $realtime);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Present one request and hold it until taken; optional idle burst after
  task automatic send_request(attitude_req_t r, int gap);
    cw <= r.cw; cx <= r.cx; cy <= r.cy; cz <= r.cz;
    gw <= r.gw; gx <= r.gx; gy <= r.gy; gz <= r.gz;
    joint <= r.joint;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_sent++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic signed [QB-1:0] rand_comp();
    return QB'($urandom_range(65534) - 32767);
  endfunction

  // Random attitude, mostly unit length, sometimes raw noise
  function automatic void rand_quat(output logic signed [QB-1:0] w, x, y, z);
    real a, b, c, d, n;
    if ($urandom_range(3) == 0) begin
      w = rand_comp(); x = rand_comp(); y = rand_comp(); z = rand_comp();
    end else begin
      a = real'(int'(rand_comp())); b = real'(int'(rand_comp()));
      c = real'(int'(rand_comp())); d = real'(int'(rand_comp()));
      if ($urandom_range(2) == 0) begin
        b = b / 16.0; c = c / 16.0;
      end
      n = $sqrt(a * a + b * b + c * c + d * d);
      if (n < 1.0) n = 1.0;
      w = QB'($rtoi(a / n * 32767.0)); x = QB'($rtoi(b / n * 32767.0));
      y = QB'($rtoi(c / n * 32767.0)); z = QB'($rtoi(d / n * 32767.0));
    end
  endfunction

  function automatic int pick_gap(bit quiet);
    if (quiet || $urandom_range(2) != 0) return 0;
    return $urandom_range(15, 1);
  endfunction

  initial begin
    attitude_req_t d[$];
    attitude_req_t r;
    int guard;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity, zero quaternion, extremes, saturated pitch, half-turn yaw error
    d.push_back('{32767, 0, 0, 0, 32767, 0, 0, 0, 0});
    d.push_back('{0, 0, 0, 0, 0, 0, 0, 0, 0});
    d.push_back('{0, 0, 0, 0, 0, 0, 0, 0, -32768});
    d.push_back('{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767});
    d.push_back('{-32767, -32767, -32767, -32767, -32767, -32767, -32767, -32767, -32768});
    d.push_back('{32767, 0, 32767, 0, 32767, 0, 0, 0, 0});
    d.push_back('{32767, 0, -32767, 0, 23170, 0, 23170, 0, 16384});
    d.push_back('{32767, 32767, 0, -32767, 0, 0, 32767, 0, 0});
    d.push_back('{23170, 0, 0, 23170, 23170, 0, 0, 23170, -32768});
    d.push_back('{32767, 0, 0, 0, 32767, 0, 0, 0, -32768});
    d.push_back('{0, 0, 0, 32767, 32767, 0, 0, 0, 0});
    d.push_back('{0, 0, 0, 32767, 0, 0, 0, 32767, 32767});
    d.push_back('{-32767, 0, 0, 1, 32767, 0, 0, -1, -16384});
    d.push_back('{32767, 32767, -32767, 32767, -32767, 32767, 32767, -32767, 1});
    d.push_back('{28377, 8192, 11585, -4096, 30000, -2000, 9000, 7000, 12345});
    d.push_back('{1, -1, 1, -1, -1, 1, -1, 1, -1});
    foreach (d[i]) send_request(d[i], pick_gap(i % 2 == 0));

    for (int i = 0; i < N_RANDOM; i++) begin
      rand_quat(r.cw, r.cx, r.cy, r.cz);
      if ($urandom_range(4) == 0) begin
        r.gw = r.cw; r.gx = r.cx; r.gy = r.cy; r.gz = r.cz;
      end else begin
        rand_quat(r.gw, r.gx, r.gy, r.gz);
      end
      r.joint = AB'($urandom);
      send_request(r, pick_gap(i >= N_RANDOM - TAIL_ITEMS));
    end
    start <= 1'b0;

    // drain the pipeline
    guard = 0;
    while (sb.pending_angles.size() != 0 && guard < STALL_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d attitude requests (directed corners and random attitudes);", n_sent);
    $display("checked %0d results, %0d mismatches.", sb.n_checked, sb.n_errors);
    if (sb.n_errors == 0 && sb.pending_angles.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (sb.pending_angles.size() != 0)
        $display("%0t: %0d results never arrived", $realtime, sb.pending_angles.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
